/* rtl/yfs_pkg.sv */
// Shared types, constants and helper functions for the YUYV frame statistics unit.
// This package has no dependencies. All RTL files of the block import it.
`default_nettype none

package yfs_pkg;

    // Frame size limit that the top level uses by default.
    localparam int DEFAULT_MAX_FRAME_PIXELS = 1048576;

    // Field and register widths.
    localparam int BYTE_W         = 8;
    localparam int FRAME_PIXELS_W = 21;
    localparam int RATIO_W        = 17;
    localparam int FRAME_NUM_W    = 32;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 21;

    // Values of the configuration registers after reset.
    localparam logic [FRAME_PIXELS_W-1:0] RESET_FRAME_PIXELS   = 21'd19200;
    localparam logic [BYTE_W-1:0]         RESET_EDGE_THRESHOLD = 8'd20;
    localparam logic [BYTE_W-1:0]         RESET_OBJECT_SCALE   = 8'd25;

    // 1.0 in unsigned Q16.
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

    // Q10 coefficients of the YUV to RGB conversion, and the chroma offset.
    localparam int COEF_RED_V    = 1436;
    localparam int COEF_GREEN_U  = 352;
    localparam int COEF_GREEN_V  = 731;
    localparam int COEF_BLUE_U   = 1814;
    localparam int CHROMA_OFFSET = 128;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_PIXELS   = 2'd0,
        CFG_EDGE_THRESHOLD = 2'd1,
        CFG_OBJECT_SCALE   = 2'd2
    } cfg_index_t;

    // Signed chroma correction term, already shifted down from Q10.
    typedef logic signed [9:0] chroma_term_t;

    // What one pixel lane hands to the merging stage.
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W:0]   green_blue;
        logic              edge_hit;
    } lane_result_t;

    // End-of-frame sequencer states.
    typedef enum logic [2:0] {
        FIN_IDLE,
        FIN_BRIGHT,
        FIN_WARM,
        FIN_TEXTURE,
        FIN_OBJECT,
        FIN_HOLD
    } fin_state_t;

    // Clamp a signed color sum to the byte range 0..255.
    function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [10:0] value);
        logic [BYTE_W-1:0] result;
        if (value < 11'sd0)
        begin
            result = '0;
        end
        else if (value > 11'sd255)
        begin
            result = 8'hFF;
        end
        else
        begin
            result = value[7:0];
        end
        return result;
    endfunction

endpackage

`default_nettype wire

/* rtl/yfs_pixel_lane.sv */
// One pixel lane: converts one luma sample plus shared chroma terms to RGB and
// checks the luma step to its neighbor. Depends on yfs_pkg.
`default_nettype none

module yfs_pixel_lane
    import yfs_pkg::*;
(
    input  wire logic [BYTE_W-1:0] luma,
    input  wire logic [BYTE_W-1:0] neighbor_luma,
    input  wire logic              compare_en,
    input  wire logic [BYTE_W-1:0] edge_threshold,
    input  wire chroma_term_t      red_term,
    input  wire chroma_term_t      green_term,
    input  wire chroma_term_t      blue_term,
    output lane_result_t           result
);

    logic signed [10:0] luma_s;
    logic signed [10:0] red_sum;
    logic signed [10:0] green_sum;
    logic signed [10:0] blue_sum;
    logic [BYTE_W-1:0]  green_val;
    logic [BYTE_W-1:0]  blue_val;
    logic [BYTE_W-1:0]  luma_step;

    always_comb
    begin
        luma_s    = $signed({3'b000, luma});
        red_sum   = luma_s + $signed({red_term[9], red_term});
        green_sum = luma_s - $signed({green_term[9], green_term});
        blue_sum  = luma_s + $signed({blue_term[9], blue_term});

        green_val = clamp_byte(green_sum);
        blue_val  = clamp_byte(blue_sum);

        // Magnitude of the step to the neighboring pixel.
        if (luma >= neighbor_luma)
        begin
            luma_step = luma - neighbor_luma;
        end
        else
        begin
            luma_step = neighbor_luma - luma;
        end

        result.red        = clamp_byte(red_sum);
        result.green_blue = {1'b0, green_val} + {1'b0, blue_val};
        result.edge_hit   = compare_en && (luma_step > edge_threshold);
    end

endmodule

`default_nettype wire

/* rtl/yfs_divider.sv */
// Shared restoring divider, one quotient bit per cycle, saturating at 1.0 in Q16.
// Depends on yfs_pkg.
`default_nettype none

module yfs_divider
    import yfs_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [NUM_W-1:0]   numerator,
    input  wire logic [DEN_W-1:0]   denominator,
    output logic                    done,
    output logic [RATIO_W-1:0]      quotient
);

    localparam int ACC_W  = (NUM_W > DEN_W + RATIO_W) ? NUM_W : DEN_W + RATIO_W;
    localparam int STEP_W = $clog2(RATIO_W + 1);

    logic [ACC_W-1:0]   rem_reg;
    logic [ACC_W-1:0]   dsh_reg;
    logic [RATIO_W-1:0] q_reg;
    logic               sat_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               fits;

    assign fits = rem_reg >= dsh_reg;

    // Control: the first step only checks for overflow, then one quotient bit
    // per step from the top down.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(RATIO_W);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - STEP_W'(1);
                done_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= ACC_W'(numerator);
            dsh_reg <= ACC_W'(denominator) << RATIO_W;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (step_reg == STEP_W'(RATIO_W))
            begin
                sat_reg <= fits;
            end
            else
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg <= {q_reg[RATIO_W-2:0], fits};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = (sat_reg || (q_reg > RATIO_ONE)) ? RATIO_ONE : q_reg;

endmodule

`default_nettype wire

/* rtl/yfs_frame_finish.sv */
// End-of-frame unit: captures the frame totals, runs the four ratio divisions on
// one shared divider and holds the result transaction. Depends on yfs_pkg, yfs_divider.
`default_nettype none

module yfs_frame_finish
    import yfs_pkg::*;
#(
    parameter int LUMA_W = 28,
    parameter int RED_W  = 28,
    parameter int GB_W   = 29,
    parameter int EDGE_W = 21,
    parameter int PIX_W  = 21
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [LUMA_W-1:0]      luma_total,
    input  wire logic [RED_W-1:0]       red_total,
    input  wire logic [GB_W-1:0]        green_blue_total,
    input  wire logic [EDGE_W-1:0]      edge_total,
    input  wire logic [PIX_W-1:0]       pixel_count,
    input  wire logic [BYTE_W-1:0]      object_scale,
    input  wire logic [FRAME_NUM_W-1:0] frame_count,
    output logic                        busy,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic [RATIO_W-1:0]          brightness_ratio,
    output logic [RATIO_W-1:0]          warmth_ratio,
    output logic [RATIO_W-1:0]          texture_ratio,
    output logic [BYTE_W-1:0]           object_estimate,
    output logic [FRAME_NUM_W-1:0]      frame_number
);

    localparam int NUM_A = (LUMA_W + 16 > RED_W + 17) ? LUMA_W + 16 : RED_W + 17;
    localparam int NUM_B = (EDGE_W + 16 > NUM_A) ? EDGE_W + 16 : NUM_A;
    localparam int NUM_W = NUM_B;
    localparam int DEN_A = (GB_W > PIX_W + 8) ? GB_W : PIX_W + 8;
    localparam int DEN_W = DEN_A + 1;

    fin_state_t state_reg;
    fin_state_t state_next;
    logic       launch_reg;
    logic       launch_next;

    logic [LUMA_W-1:0]      luma_reg;
    logic [RED_W-1:0]       red_reg;
    logic [GB_W-1:0]        gb_reg;
    logic [EDGE_W-1:0]      edge_reg;
    logic [PIX_W-1:0]       pix_reg;
    logic [BYTE_W-1:0]      scale_reg;
    logic [FRAME_NUM_W-1:0] frame_reg;

    logic [RATIO_W-1:0]     bright_reg;
    logic [RATIO_W-1:0]     warm_reg;
    logic [RATIO_W-1:0]     texture_reg;
    logic [BYTE_W-1:0]      object_reg;

    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic                   div_done;
    logic [RATIO_W-1:0]     div_quot;
    logic [EDGE_W+7:0]      scaled_edges;

    yfs_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (launch_reg),
        .numerator   (div_num),
        .denominator (div_den),
        .done        (div_done),
        .quotient    (div_quot)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FIN_IDLE:
            begin
                if (start)
                begin
                    state_next = FIN_BRIGHT;
                end
            end
            FIN_BRIGHT:
            begin
                if (div_done)
                begin
                    state_next = FIN_WARM;
                end
            end
            FIN_WARM:
            begin
                if (div_done)
                begin
                    state_next = FIN_TEXTURE;
                end
            end
            FIN_TEXTURE:
            begin
                if (div_done)
                begin
                    state_next = FIN_OBJECT;
                end
            end
            FIN_OBJECT:
            begin
                if (div_done)
                begin
                    state_next = FIN_HOLD;
                end
            end
            FIN_HOLD:
            begin
                if (result_ready)
                begin
                    state_next = FIN_IDLE;
                end
            end
            default:
            begin
                state_next = FIN_IDLE;
            end
        endcase
    end

    // Outputs: divider operands by state, and a launch on entry to each division.
    always_comb
    begin
        scaled_edges = scale_reg * edge_reg;
        div_num      = '0;
        div_den      = DEN_W'(pix_reg) << 1;
        unique case (state_reg)
            FIN_BRIGHT:
            begin
                div_num = NUM_W'(luma_reg) << 16;
                div_den = (DEN_W'(pix_reg) << 8) - DEN_W'(pix_reg);
            end
            FIN_WARM:
            begin
                div_num = NUM_W'(red_reg) << 17;
                div_den = DEN_W'(gb_reg) + DEN_W'(pix_reg);
            end
            FIN_TEXTURE:
            begin
                div_num = NUM_W'(edge_reg) << 16;
            end
            FIN_OBJECT:
            begin
                div_num = NUM_W'(scaled_edges);
            end
            FIN_IDLE, FIN_HOLD:
            begin
                div_num = '0;
            end
            default:
            begin
                div_num = '0;
            end
        endcase

        launch_next = 1'b0;
        case (state_next) inside
            FIN_BRIGHT, FIN_WARM, FIN_TEXTURE, FIN_OBJECT:
            begin
                launch_next = (state_next != state_reg);
            end
            default:
            begin
                launch_next = 1'b0;
            end
        endcase

        busy         = (state_reg != FIN_IDLE);
        result_valid = (state_reg == FIN_HOLD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FIN_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    // Frame totals are captured once; the accumulators upstream are free again.
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == FIN_IDLE))
        begin
            luma_reg  <= luma_total;
            red_reg   <= red_total;
            gb_reg    <= green_blue_total;
            edge_reg  <= edge_total;
            pix_reg   <= pixel_count;
            scale_reg <= object_scale;
            frame_reg <= frame_count;
        end
        if (div_done)
        begin
            case (state_reg)
                FIN_BRIGHT:  bright_reg  <= div_quot;
                FIN_WARM:    warm_reg    <= div_quot;
                FIN_TEXTURE: texture_reg <= div_quot;
                FIN_OBJECT:
                begin
                    if (div_quot > RATIO_W'(scale_reg))
                    begin
                        object_reg <= scale_reg;
                    end
                    else
                    begin
                        object_reg <= div_quot[BYTE_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign brightness_ratio = bright_reg;
    assign warmth_ratio     = warm_reg;
    assign texture_ratio    = texture_reg;
    assign object_estimate  = object_reg;
    assign frame_number     = frame_reg;

endmodule

`default_nettype wire

/* rtl/yuyv_frame_statistics_unit.sv */
// Top level of the YUYV frame statistics unit: stream ports, configuration
// registers, two pixel lanes, the merging accumulators and the end-of-frame unit.
// Depends on yfs_pkg, yfs_pixel_lane, yfs_frame_finish.
//
// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+-----------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | one YUYV macropixel (two pixels)
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | frame ratios, object count, frame no.
// cfg       | in        | cfg_write (no wait)            | frame_pixels, edge_threshold, scale
//
// Macropixels are taken at one transaction per clock while s_axis_tready is high.
// Both pixels are converted in parallel lanes in the cycle of acceptance, and their
// sums are merged into the frame accumulators in the cycle after. A frame's result
// is valid once its last macropixel has passed the merge stage and the end-of-frame
// unit has run four divisions in turn on the shared divider (each a launch, the
// divider steps and a done). The last macropixel of a frame is held off while the
// previous frame's last macropixel is merged, its divisions run or its result has
// not yet been taken; a frame that ends before then stalls once. Reset clears all
// counters, sums and the configuration to its defaults; no clearing pass is needed.
`default_nettype none

module yuyv_frame_statistics_unit
    import yfs_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = DEFAULT_MAX_FRAME_PIXELS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // tdata: luma_first [7:0], chroma_blue [15:8], luma_second [23:16],
    // chroma_red [31:24].
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [31:0]            s_axis_tdata,

    // tdata: brightness_ratio [16:0], warmth_ratio [33:17], texture_ratio [50:34],
    // object_estimate [58:51], frame_number [90:59], zeros [95:91].
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [95:0]                 m_axis_tdata,

    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam longint MAX_PIX  = longint'(MAX_FRAME_PIXELS);
    localparam int     ITEM_MAX = (MAX_FRAME_PIXELS / 2 < 1) ? 1 : MAX_FRAME_PIXELS / 2;
    localparam int     IDX_W    = (ITEM_MAX > 1) ? $clog2(ITEM_MAX) : 1;
    localparam int     ITEM_W   = $clog2(ITEM_MAX + 1);
    localparam int     CMP_W    = ITEM_W + 1;
    localparam int     PIX_W    = ITEM_W + 1;
    localparam int     LUMA_W   = $clog2(MAX_PIX * 255 + 1);
    localparam int     GB_W     = $clog2(MAX_PIX * 510 + 1);
    localparam int     EDGE_W   = PIX_W;

    // Configuration registers.
    logic [FRAME_PIXELS_W-1:0] frame_pixels_reg;
    logic [BYTE_W-1:0]         edge_threshold_reg;
    logic [BYTE_W-1:0]         object_scale_reg;

    // Input side state.
    logic [IDX_W-1:0]          index_reg;
    logic [IDX_W-1:0]          index_next;
    logic [BYTE_W-1:0]         prev_luma_reg;

    // Merge stage registers.
    logic                      s1_valid_reg;
    logic                      s1_last_reg;
    logic [BYTE_W:0]           s1_luma_reg;
    logic [BYTE_W:0]           s1_red_reg;
    logic [BYTE_W+1:0]         s1_gb_reg;
    logic [1:0]                s1_edges_reg;

    // Frame accumulators.
    logic [LUMA_W-1:0]         luma_acc_reg;
    logic [LUMA_W-1:0]         red_acc_reg;
    logic [GB_W-1:0]           gb_acc_reg;
    logic [EDGE_W-1:0]         edge_acc_reg;
    logic [FRAME_NUM_W-1:0]    frames_done_reg;

    logic [LUMA_W-1:0]         luma_total;
    logic [LUMA_W-1:0]         red_total;
    logic [GB_W-1:0]           gb_total;
    logic [EDGE_W-1:0]         edge_total;
    logic [FRAME_NUM_W-1:0]    frame_count;
    logic                      frame_end;

    logic [BYTE_W-1:0]         luma_first;
    logic [BYTE_W-1:0]         chroma_blue;
    logic [BYTE_W-1:0]         luma_second;
    logic [BYTE_W-1:0]         chroma_red;

    logic signed [9:0]         u_s;
    logic signed [9:0]         v_s;
    logic signed [19:0]        red_prod;
    logic signed [19:0]        green_prod;
    logic signed [19:0]        blue_prod;
    logic signed [19:0]        red_shift;
    logic signed [19:0]        green_shift;
    logic signed [19:0]        blue_shift;
    chroma_term_t              red_term;
    chroma_term_t              green_term;
    chroma_term_t              blue_term;

    logic [FRAME_PIXELS_W-2:0] half_pixels;
    logic [ITEM_W-1:0]         items;
    logic [CMP_W-1:0]          index_plus;
    logic                      is_last;
    logic                      end_busy;
    logic                      accept;

    lane_result_t              lane0_result;
    lane_result_t              lane1_result;
    logic                      fin_busy;

    assign luma_first  = s_axis_tdata[7:0];
    assign chroma_blue = s_axis_tdata[15:8];
    assign luma_second = s_axis_tdata[23:16];
    assign chroma_red  = s_axis_tdata[31:24];

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg   <= RESET_FRAME_PIXELS;
            edge_threshold_reg <= RESET_EDGE_THRESHOLD;
            object_scale_reg   <= RESET_OBJECT_SCALE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_PIXELS:   frame_pixels_reg   <= cfg_data[FRAME_PIXELS_W-1:0];
                CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[BYTE_W-1:0];
                CFG_OBJECT_SCALE:   object_scale_reg   <= cfg_data[BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Macropixels per frame: half the pixel count, kept within 1 and the limit.
    always_comb
    begin
        half_pixels = frame_pixels_reg[FRAME_PIXELS_W-1:1];
        if (half_pixels == '0)
        begin
            items = ITEM_W'(1);
        end
        else if (32'(half_pixels) > 32'(ITEM_MAX))
        begin
            items = ITEM_W'(ITEM_MAX);
        end
        else
        begin
            items = ITEM_W'(half_pixels);
        end

        // A shortened frame length ends the frame at the next macropixel.
        index_plus = CMP_W'(index_reg) + CMP_W'(1);
        is_last    = (index_plus >= CMP_W'(items));
        index_next = is_last ? '0 : index_reg + IDX_W'(1);
    end

    // The frame's last macropixel waits while a frame end is in the merge stage or the end-of-frame unit is busy.
    assign end_busy      = (s1_valid_reg && s1_last_reg) || fin_busy;
    assign s_axis_tready = !(is_last && end_busy);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Shared chroma terms; arithmetic right shift floors the Q10 products.
    always_comb
    begin
        u_s         = $signed({2'b00, chroma_blue}) - 10'sd128;
        v_s         = $signed({2'b00, chroma_red}) - 10'sd128;
        red_prod    = $signed(20'(COEF_RED_V)) * $signed({{10{v_s[9]}}, v_s});
        green_prod  = $signed(20'(COEF_GREEN_U)) * $signed({{10{u_s[9]}}, u_s})
                    + $signed(20'(COEF_GREEN_V)) * $signed({{10{v_s[9]}}, v_s});
        blue_prod   = $signed(20'(COEF_BLUE_U)) * $signed({{10{u_s[9]}}, u_s});
        red_shift   = red_prod >>> 10;
        green_shift = green_prod >>> 10;
        blue_shift  = blue_prod >>> 10;
        red_term    = red_shift[9:0];
        green_term  = green_shift[9:0];
        blue_term   = blue_shift[9:0];
    end

    // Lane 0 compares the first pixel with the last pixel of the previous
    // macropixel; lane 1 compares the second pixel with the first.
    yfs_pixel_lane u_lane0 (
        .luma           (luma_first),
        .neighbor_luma  (prev_luma_reg),
        .compare_en     (index_reg != '0),
        .edge_threshold (edge_threshold_reg),
        .red_term       (red_term),
        .green_term     (green_term),
        .blue_term      (blue_term),
        .result         (lane0_result)
    );

    yfs_pixel_lane u_lane1 (
        .luma           (luma_second),
        .neighbor_luma  (luma_first),
        .compare_en     (index_reg != '0),
        .edge_threshold (edge_threshold_reg),
        .red_term       (red_term),
        .green_term     (green_term),
        .blue_term      (blue_term),
        .result         (lane1_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            prev_luma_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                index_reg     <= index_next;
                prev_luma_reg <= luma_second;
                s1_last_reg   <= is_last;
            end
        end
    end

    // Merge what the two lanes found into one contribution per macropixel.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_luma_reg  <= {1'b0, luma_first} + {1'b0, luma_second};
            s1_red_reg   <= {1'b0, lane0_result.red} + {1'b0, lane1_result.red};
            s1_gb_reg    <= {1'b0, lane0_result.green_blue}
                          + {1'b0, lane1_result.green_blue};
            s1_edges_reg <= {1'b0, lane0_result.edge_hit} + {1'b0, lane1_result.edge_hit};
        end
    end

    always_comb
    begin
        luma_total  = luma_acc_reg + LUMA_W'(s1_luma_reg);
        red_total   = red_acc_reg + LUMA_W'(s1_red_reg);
        gb_total    = gb_acc_reg + GB_W'(s1_gb_reg);
        edge_total  = edge_acc_reg + EDGE_W'(s1_edges_reg);
        frame_count = frames_done_reg + FRAME_NUM_W'(1);
        frame_end   = s1_valid_reg && s1_last_reg;
    end

    // Accumulators restart from zero once the frame totals are handed over.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_acc_reg    <= '0;
            red_acc_reg     <= '0;
            gb_acc_reg      <= '0;
            edge_acc_reg    <= '0;
            frames_done_reg <= '0;
        end
        else if (frame_end)
        begin
            luma_acc_reg    <= '0;
            red_acc_reg     <= '0;
            gb_acc_reg      <= '0;
            edge_acc_reg    <= '0;
            frames_done_reg <= frame_count;
        end
        else if (s1_valid_reg)
        begin
            luma_acc_reg <= luma_total;
            red_acc_reg  <= red_total;
            gb_acc_reg   <= gb_total;
            edge_acc_reg <= edge_total;
        end
    end

    logic [RATIO_W-1:0]     brightness_ratio;
    logic [RATIO_W-1:0]     warmth_ratio;
    logic [RATIO_W-1:0]     texture_ratio;
    logic [BYTE_W-1:0]      object_estimate;
    logic [FRAME_NUM_W-1:0] frame_number;

    yfs_frame_finish #(
        .LUMA_W (LUMA_W),
        .RED_W  (LUMA_W),
        .GB_W   (GB_W),
        .EDGE_W (EDGE_W),
        .PIX_W  (PIX_W)
    ) u_finish (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (frame_end),
        .luma_total       (luma_total),
        .red_total        (red_total),
        .green_blue_total (gb_total),
        .edge_total       (edge_total),
        .pixel_count      ({items, 1'b0}),
        .object_scale     (object_scale_reg),
        .frame_count      (frame_count),
        .busy             (fin_busy),
        .result_valid     (m_axis_tvalid),
        .result_ready     (m_axis_tready),
        .brightness_ratio (brightness_ratio),
        .warmth_ratio     (warmth_ratio),
        .texture_ratio    (texture_ratio),
        .object_estimate  (object_estimate),
        .frame_number     (frame_number)
    );

    assign m_axis_tdata = {5'b00000, frame_number, object_estimate, texture_ratio,
                           warmth_ratio, brightness_ratio};

endmodule

`default_nettype wire
